// File: sv/ifa_pkg.sv
// ifa_pkg: shared widths, character codes, mode codes and helper functions
// for the integer to ascii formatter; depends on nothing
`timescale 1ns / 1ps

package ifa_pkg;

	localparam int VALUE_W  = 32;
	localparam int MODE_W   = 2;
	localparam int CHAR_W   = 8;
	localparam int DEC_DIGS = 10;
	localparam int BCD_W    = 4 * DEC_DIGS;
	localparam int BUF_LEN  = 11;
	localparam int POS_W    = 4;

	localparam logic [POS_W-1:0] LAST_POS  = POS_W'(BUF_LEN - 1);
	localparam logic [POS_W-1:0] HEX_FIRST = POS_W'(3);

	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [BCD_W-1:0]   bcd_t;
	typedef logic [POS_W-1:0]   pos_t;
	typedef char_t [BUF_LEN-1:0] text_buf_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_UDEC = 2'd0,
		MODE_SDEC = 2'd1,
		MODE_HEX  = 2'd2,
		MODE_PTR  = 2'd3
	} mode_t;

	localparam char_t CHAR_ZERO  = 8'h30;
	localparam char_t CHAR_X     = 8'h78;
	localparam char_t CHAR_UPA   = 8'h41;
	localparam char_t CHAR_MINUS = 8'h2D;

	// one double-dabble step: correct every digit then shift a bit in
	function automatic bcd_t dab_step(bcd_t b, logic din);
		bcd_t c;
		c = b;
		for (int i = 0; i < DEC_DIGS; i++) begin
			if (c[4*i +: 4] >= 4'd5) begin
				c[4*i +: 4] = c[4*i +: 4] + 4'd3;
			end
		end
		return {c[BCD_W-2:0], din};
	endfunction

	// eight dabble steps, msb of the byte first
	function automatic bcd_t dab_byte(bcd_t b, logic [7:0] bits);
		bcd_t c;
		c = b;
		for (int i = 7; i >= 0; i--) begin
			c = dab_step(c, bits[i]);
		end
		return c;
	endfunction

	// uppercase hex digit
	function automatic char_t hex_char(logic [3:0] d);
		char_t r;
		if (d > 4'd9) begin
			r = {4'b0000, d} + (CHAR_UPA - 8'd10);
		end else begin
			r = {4'b0000, d} + CHAR_ZERO;
		end
		return r;
	endfunction

endpackage

// File: sv/ifa_if.sv
// ifa_in_if and ifa_out_if: valid/ready channels for number beats and
// character beats; depends on ifa_pkg
`timescale 1ns / 1ps

interface ifa_in_if
	import ifa_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic [MODE_W-1:0]  mode;

	modport source (output valid, output value, output mode, input ready);
	modport sink   (input valid, input value, input mode, output ready);
endinterface

interface ifa_out_if
	import ifa_pkg::*;
();
	logic  valid;
	logic  ready;
	char_t char_code;
	logic  last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink   (input valid, input char_code, input last, output ready);
endinterface

// File: sv/integer_to_ascii_formatter.sv
// integer_to_ascii_formatter: an accepted number beat passes the sign stage,
// four dabble stages, the format stage and the serialiser before its first
// character beat. throughput: one character beat per cycle while text.ready
// is high; a number's text has 1 to 11 characters, all sent through the
// serialiser's single port; the next number loads as the last one is taken.
// reset: arst_n clears all stage valid bits and the serialiser at once.
`timescale 1ns / 1ps

module integer_to_ascii_formatter
	import ifa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ifa_in_if.sink     item,
	ifa_out_if.source  text
);

	// stage valid bits and ready chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, ser_rdy;

	logic [VALUE_W-1:0] raw_s1, raw_s2, raw_s3, raw_s4, raw_s5;
	mode_t              mode_s1, mode_s2, mode_s3, mode_s4, mode_s5;
	logic               neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	bcd_t               bcd_s2, bcd_s3, bcd_s4, bcd_s5;

	text_buf_t buf_s6;
	pos_t      start_s6;

	logic      ser_vld_q;
	text_buf_t ser_buf_q;
	pos_t      ptr_q;

	logic      text_last;

	assign text_last = (ptr_q == LAST_POS);
	assign ser_rdy   = !ser_vld_q || (text.ready && text_last);
	assign rdy6      = !v_s6 || ser_rdy;
	assign rdy5      = !v_s5 || rdy6;
	assign rdy4      = !v_s4 || rdy5;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign item.ready = rdy1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= item.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	// stage 1: magnitude, negated for a negative signed number
	always_ff @(posedge clk) begin
		if (rdy1 && item.valid) begin
			mode_s1 <= mode_t'(item.mode);
			neg_s1  <= (mode_t'(item.mode) == MODE_SDEC) && item.value[VALUE_W-1];
			if ((mode_t'(item.mode) == MODE_SDEC) && item.value[VALUE_W-1]) begin
				raw_s1 <= VALUE_W'(0) - item.value;
			end else begin
				raw_s1 <= item.value;
			end
		end
	end

	// stages 2 to 5: binary to bcd, one byte per stage
	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			raw_s2  <= raw_s1;
			mode_s2 <= mode_s1;
			neg_s2  <= neg_s1;
			bcd_s2  <= dab_byte('0, raw_s1[31:24]);
		end
		if (rdy3 && v_s2) begin
			raw_s3  <= raw_s2;
			mode_s3 <= mode_s2;
			neg_s3  <= neg_s2;
			bcd_s3  <= dab_byte(bcd_s2, raw_s2[23:16]);
		end
		if (rdy4 && v_s3) begin
			raw_s4  <= raw_s3;
			mode_s4 <= mode_s3;
			neg_s4  <= neg_s3;
			bcd_s4  <= dab_byte(bcd_s3, raw_s3[15:8]);
		end
		if (rdy5 && v_s4) begin
			raw_s5  <= raw_s4;
			mode_s5 <= mode_s4;
			neg_s5  <= neg_s4;
			bcd_s5  <= dab_byte(bcd_s4, raw_s4[7:0]);
		end
	end

	// stage 6 logic: first digit position, prefix placed just before it
	text_buf_t buf_nxt;
	pos_t      start_nxt;

	always_comb begin
		pos_t  f;
		pos_t  plen;
		logic  is_hex;
		char_t digch;
		is_hex = (mode_s5 == MODE_HEX) || (mode_s5 == MODE_PTR);
		f = LAST_POS;
		if (mode_s5 == MODE_PTR) begin
			f = HEX_FIRST;
		end else if (is_hex) begin
			for (int p = BUF_LEN - 1; p >= 3; p--) begin
				if (raw_s5[4*(BUF_LEN-1-p) +: 4] != 4'd0) f = POS_W'(p);
			end
		end else begin
			for (int p = BUF_LEN - 1; p >= 1; p--) begin
				if (bcd_s5[4*(BUF_LEN-1-p) +: 4] != 4'd0) f = POS_W'(p);
			end
		end
		case (mode_s5)
			MODE_UDEC: plen = POS_W'(0);
			MODE_SDEC: plen = neg_s5 ? POS_W'(1) : POS_W'(0);
			default:   plen = POS_W'(2);
		endcase
		start_nxt = f - plen;

		// leftmost slot only ever holds a prefix character
		buf_nxt[0] = is_hex ? CHAR_ZERO : CHAR_MINUS;
		for (int p = 1; p < BUF_LEN; p++) begin
			if (is_hex) begin
				if (p >= 3) digch = hex_char(raw_s5[4*(BUF_LEN-1-p) +: 4]);
				else        digch = CHAR_ZERO;
			end else begin
				digch = {4'b0000, bcd_s5[4*(BUF_LEN-1-p) +: 4]} + CHAR_ZERO;
			end
			if (POS_W'(p) >= f) begin
				buf_nxt[p] = digch;
			end else if (is_hex && (POS_W'(p) == f - POS_W'(1))) begin
				buf_nxt[p] = CHAR_X;
			end else if (is_hex) begin
				buf_nxt[p] = CHAR_ZERO;
			end else begin
				buf_nxt[p] = CHAR_MINUS;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy6 && v_s5) begin
			buf_s6   <= buf_nxt;
			start_s6 <= start_nxt;
		end
	end

	// serialiser: one character beat per cycle while text.ready is high, from start to the last slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_vld_q <= 1'b0;
			ptr_q     <= '0;
		end else if (ser_rdy) begin
			ser_vld_q <= v_s6;
			if (v_s6) ptr_q <= start_s6;
		end else if (text.ready) begin
			ptr_q <= ptr_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ser_rdy && v_s6) ser_buf_q <= buf_s6;
	end

	assign text.valid     = ser_vld_q;
	assign text.char_code = ser_buf_q[ptr_q];
	assign text.last      = text_last;

`ifndef SYNTHESIS
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ser_vld_q |-> (ptr_q <= LAST_POS))
		else $error("serialiser pointer beyond last slot");

	a_s6_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && !ser_rdy) |=> (v_s6 && $stable(start_s6)))
		else $error("stalled format stage lost its beat");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !rdy2) |=> (v_s1 && $stable(raw_s1)))
		else $error("stalled sign stage changed");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(text.valid && text.ready && text.last && !v_s6) |=> !ser_vld_q)
		else $error("serialiser repeated a finished number");
`endif

endmodule
